/* rtl/core/wsft_pkg.sv */
// shared types and constants of the ws2812 frame transmitter
// no dependencies
package wsft_pkg;

  localparam int MAX_LEDS_DEF = 64;

  localparam int FUNC_W    = 2;
  localparam int BYTE_W    = 8;
  localparam int WORD_W    = 24;
  localparam int CFG_W     = 16;
  localparam int LED_CNT_W = 7;
  localparam int CFG_IDX_W = 3;
  localparam int BIT_W     = 5;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_W-1:0]     PERIOD_RST    = 16'd90;
  localparam logic [CFG_W-1:0]     ONE_HIGH_RST  = 16'd65;
  localparam logic [CFG_W-1:0]     ZERO_HIGH_RST = 16'd24;
  localparam logic [CFG_W-1:0]     RST_SLOTS_RST = 16'd6000;
  localparam logic [LED_CNT_W-1:0] LED_CNT_RST   = 7'd1;
  localparam logic [BIT_W-1:0]     LAST_BIT      = 5'd23;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_SET_ONE = 2'd0,
    FUNC_SET_ALL = 2'd1,
    FUNC_START   = 2'd2,
    FUNC_TICK    = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD    = 3'd0,
    CFG_ONE_HIGH  = 3'd1,
    CFG_ZERO_HIGH = 3'd2,
    CFG_RST_SLOTS = 3'd3,
    CFG_LED_COUNT = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_WRITE,
    OP_FILL,
    OP_START,
    OP_DROP
  } op_kind_t;

  typedef struct packed {
    op_kind_t            kind;
    logic [BYTE_W-1:0]   idx;
    logic [WORD_W-1:0]   word;
  } op_t;

  typedef struct packed {
    logic [CFG_W-1:0]     period;
    logic [CFG_W-1:0]     one_high;
    logic [CFG_W-1:0]     zero_high;
    logic [CFG_W-1:0]     rst_slots;
    logic [LED_CNT_W-1:0] led_count;
  } cfg_t;

endpackage

/* rtl/core/wsft_ram.sv */
// generic single write port ram with registered read
// no dependencies
module wsft_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/wsft_front.sv */
// command front end: accepts beats and classifies them into queue ops
// depends on wsft_pkg
module wsft_front
  import wsft_pkg::*;
(
  input  logic                 start,
  output logic                 busy,
  input  logic [FUNC_W-1:0]    func,
  input  logic [BYTE_W-1:0]    led_index,
  input  logic [BYTE_W-1:0]    red,
  input  logic [BYTE_W-1:0]    green,
  input  logic [BYTE_W-1:0]    blue,
  input  logic [LED_CNT_W-1:0] led_cnt,
  input  logic                 queue_full,
  input  logic                 clearing,
  output logic                 push,
  output op_t                  op
);

  func_t f;

  assign f    = func_t'(func);
  assign busy = queue_full | clearing;
  assign push = start & ~busy;

  always_comb begin
    op.idx  = led_index;
    op.word = {green, red, blue};
    unique case (f)
      FUNC_SET_ONE: begin
        op.kind = ({1'b0, led_index} < 9'(led_cnt)) ? OP_WRITE : OP_DROP;
      end
      FUNC_SET_ALL: op.kind = OP_FILL;
      FUNC_START:   op.kind = OP_START;
      FUNC_TICK:    op.kind = OP_TICK;
      default:      op.kind = OP_DROP;
    endcase
  end

endmodule

/* rtl/core/wsft_queue.sv */
// two entry op queue between front end and back end
// depends on wsft_pkg
module wsft_queue
  import wsft_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_op,
  input  logic pop,
  output op_t  head_op,
  output logic empty,
  output logic full
);

  op_t                    mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_CNT_W-1:0] cnt_r;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign head_op = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/wsft_back.sv */
// back end: executes queued ops, sweeps the color store, shapes the line
// depends on wsft_pkg; drives the color store ram ports
module wsft_back
  import wsft_pkg::*;
#(
  parameter int MAX_LEDS = MAX_LEDS_DEF,
  parameter int AW       = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  input  logic [LED_CNT_W-1:0] led_cnt,
  input  op_t                  head_op,
  input  logic                 empty,
  output logic                 pop,
  output logic                 clearing,
  output logic                 ram_we,
  output logic [AW-1:0]        ram_waddr,
  output logic [WORD_W-1:0]    ram_wdata,
  output logic [AW-1:0]        ram_raddr,
  input  logic [WORD_W-1:0]    ram_rdata,
  output logic                 out_valid,
  output logic                 out_line_level,
  output logic                 out_busy_res,
  output logic                 out_frame_done,
  output logic                 out_accepted
);

  localparam int CW = $clog2(MAX_LEDS + 1);

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_RUN,
    BK_FILL
  } bk_state_t;

  bk_state_t         state_r, state_nxt;
  logic [AW-1:0]     sweep_idx_r, sweep_idx_nxt;
  logic [CW-1:0]     sweep_len_r, sweep_len_nxt;
  logic [WORD_W-1:0] fill_word_r, fill_word_nxt;
  logic              sending_r, sending_nxt;
  logic              in_rst_r, in_rst_nxt;
  logic [CFG_W-1:0]  tick_r, tick_nxt;
  logic [BIT_W-1:0]  bit_r, bit_nxt;
  logic [AW-1:0]     led_r, led_nxt;
  logic [CFG_W-1:0]  rslot_r, rslot_nxt;
  logic              valid_r, valid_nxt;
  logic              level_r, level_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              acc_r, acc_nxt;

  logic              sweep_last;
  logic              cur_bit;
  logic [CFG_W-1:0]  high_cnt;

  assign sweep_last = (17'(sweep_idx_r) + 17'd1) >= 17'(sweep_len_r);
  assign cur_bit    = ram_rdata[LAST_BIT - bit_r];
  assign high_cnt   = cur_bit ? cfg.one_high : cfg.zero_high;
  assign clearing   = (state_r == BK_CLEAR);
  assign ram_raddr  = led_nxt;

  always_comb begin
    state_nxt     = state_r;
    sweep_idx_nxt = sweep_idx_r;
    sweep_len_nxt = sweep_len_r;
    fill_word_nxt = fill_word_r;
    sending_nxt   = sending_r;
    in_rst_nxt    = in_rst_r;
    tick_nxt      = tick_r;
    bit_nxt       = bit_r;
    led_nxt       = led_r;
    rslot_nxt     = rslot_r;
    valid_nxt     = 1'b0;
    level_nxt     = 1'b0;
    done_nxt      = 1'b0;
    acc_nxt       = 1'b0;
    pop           = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = sweep_idx_r;
    ram_wdata     = fill_word_r;

    unique case (state_r)
      BK_CLEAR, BK_FILL: begin
        ram_we = 1'b1;
        if (state_r == BK_CLEAR) begin
          ram_wdata = '0;
        end
        if (sweep_last) begin
          state_nxt     = BK_RUN;
          sweep_idx_nxt = '0;
        end else begin
          sweep_idx_nxt = sweep_idx_r + 1'b1;
        end
      end
      BK_RUN: begin
        if (!empty) begin
          pop       = 1'b1;
          valid_nxt = 1'b1;
          case (head_op.kind)
            OP_TICK: begin
              acc_nxt = 1'b1;
              if (sending_r) begin
                level_nxt = ~in_rst_r & (tick_r < high_cnt);
                if ((17'(tick_r) + 17'd1) >= 17'(cfg.period)) begin
                  tick_nxt = '0;
                  if (in_rst_r) begin
                    if ((17'(rslot_r) + 17'd1) >= 17'(cfg.rst_slots)) begin
                      sending_nxt = 1'b0;
                      in_rst_nxt  = 1'b0;
                      led_nxt     = '0;
                      rslot_nxt   = '0;
                      done_nxt    = 1'b1;
                    end else begin
                      rslot_nxt = rslot_r + 1'b1;
                    end
                  end else if (bit_r < LAST_BIT) begin
                    bit_nxt = bit_r + 1'b1;
                  end else begin
                    bit_nxt = '0;
                    if ((17'(led_r) + 17'd1) < 17'(led_cnt)) begin
                      led_nxt = led_r + 1'b1;
                    end else if (cfg.rst_slots == '0) begin
                      sending_nxt = 1'b0;
                      led_nxt     = '0;
                      done_nxt    = 1'b1;
                    end else begin
                      in_rst_nxt = 1'b1;
                      rslot_nxt  = '0;
                    end
                  end
                end else begin
                  tick_nxt = tick_r + 1'b1;
                end
              end
            end
            OP_WRITE: begin
              if (!sending_r) begin
                ram_we    = 1'b1;
                ram_waddr = AW'(head_op.idx);
                ram_wdata = head_op.word;
                acc_nxt   = 1'b1;
              end
            end
            OP_FILL: begin
              if (!sending_r) begin
                acc_nxt = 1'b1;
                if (led_cnt != '0) begin
                  state_nxt     = BK_FILL;
                  sweep_idx_nxt = '0;
                  sweep_len_nxt = CW'(led_cnt);
                  fill_word_nxt = head_op.word;
                end
              end
            end
            OP_START: begin
              if (!sending_r) begin
                acc_nxt    = 1'b1;
                in_rst_nxt = 1'b0;
                tick_nxt   = '0;
                bit_nxt    = '0;
                led_nxt    = '0;
                rslot_nxt  = '0;
                if (led_cnt != '0 || cfg.rst_slots != '0) begin
                  sending_nxt = 1'b1;
                  in_rst_nxt  = (led_cnt == '0);
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: state_nxt = BK_RUN;
    endcase

    busy_nxt = sending_nxt;
  end

  always_ff @(posedge clk) begin
    fill_word_r <= fill_word_nxt;
    level_r     <= level_nxt;
    busy_r      <= busy_nxt;
    done_r      <= done_nxt;
    acc_r       <= acc_nxt;
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      sweep_idx_r <= '0;
      sweep_len_r <= CW'(MAX_LEDS);
      sending_r   <= 1'b0;
      in_rst_r    <= 1'b0;
      tick_r      <= '0;
      bit_r       <= '0;
      led_r       <= '0;
      rslot_r     <= '0;
      valid_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_idx_r <= sweep_idx_nxt;
      sweep_len_r <= sweep_len_nxt;
      sending_r   <= sending_nxt;
      in_rst_r    <= in_rst_nxt;
      tick_r      <= tick_nxt;
      bit_r       <= bit_nxt;
      led_r       <= led_nxt;
      rslot_r     <= rslot_nxt;
      valid_r     <= valid_nxt;
    end
  end

  assign out_valid      = valid_r;
  assign out_line_level = level_r;
  assign out_busy_res   = busy_r;
  assign out_frame_done = done_r;
  assign out_accepted   = acc_r;

endmodule

/* rtl/core/ws2812_frame_transmitter_top.sv */
// ws2812 frame transmitter top: config registers, front end, queue, back end, color ram
// depends on wsft_pkg, wsft_front, wsft_queue, wsft_back, wsft_ram
//
// usage: a command beat (in_func, in_led_index, in_red/green/blue) is taken when start is
// high and busy is low. func selects set one led, set all leds, start frame or tick.
// every beat gives exactly one result, shown for one cycle with out_valid high, after it
// passes the queue entry and the back end output register; results keep beat order and
// cannot be held off. beats queued behind a set all wait for its ram sweep.
// one beat is taken per clock while busy is low, so a tick each clock drives the line at
// full rate; the front end and back end meet in a two entry queue.
// set all walks the color ram one entry a cycle (first led_count entries, ram write port);
// the queue keeps taking beats until full, then busy rises.
// set, set all and start beats given during a frame return out_accepted low.
// after reset the color ram is cleared by a pass over its MAX_LEDS entries, while busy
// is high; config registers return to 90/65/24/6000/1.
// the cfg port (cfg_valid, cfg_ready, cfg_index, cfg_data) is always ready and must only
// be written while no command results are outstanding.
module ws2812_frame_transmitter_top
  import wsft_pkg::*;
#(
  parameter int MAX_LEDS = MAX_LEDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [FUNC_W-1:0]    in_func,
  input  logic [BYTE_W-1:0]    in_led_index,
  input  logic [BYTE_W-1:0]    in_red,
  input  logic [BYTE_W-1:0]    in_green,
  input  logic [BYTE_W-1:0]    in_blue,
  output logic                 out_valid,
  output logic                 out_line_level,
  output logic                 out_busy_res,
  output logic                 out_frame_done,
  output logic                 out_accepted,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

  cfg_t                 cfg_r;
  logic [LED_CNT_W-1:0] led_cnt;
  logic                 push, pop, q_empty, q_full, clearing;
  op_t                  push_op, head_op;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [WORD_W-1:0]    ram_wdata, ram_rdata;

  assign cfg_ready = 1'b1;
  assign led_cnt   = (32'(cfg_r.led_count) > MAX_LEDS) ? LED_CNT_W'(MAX_LEDS)
                                                       : cfg_r.led_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.period    <= PERIOD_RST;
      cfg_r.one_high  <= ONE_HIGH_RST;
      cfg_r.zero_high <= ZERO_HIGH_RST;
      cfg_r.rst_slots <= RST_SLOTS_RST;
      cfg_r.led_count <= LED_CNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PERIOD:    cfg_r.period    <= cfg_data;
        CFG_ONE_HIGH:  cfg_r.one_high  <= cfg_data;
        CFG_ZERO_HIGH: cfg_r.zero_high <= cfg_data;
        CFG_RST_SLOTS: cfg_r.rst_slots <= cfg_data;
        CFG_LED_COUNT: cfg_r.led_count <= cfg_data[LED_CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  wsft_front u_front (
    .start      (start),
    .busy       (busy),
    .func       (in_func),
    .led_index  (in_led_index),
    .red        (in_red),
    .green      (in_green),
    .blue       (in_blue),
    .led_cnt    (led_cnt),
    .queue_full (q_full),
    .clearing   (clearing),
    .push       (push),
    .op         (push_op)
  );

  wsft_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head_op (head_op),
    .empty   (q_empty),
    .full    (q_full)
  );

  wsft_back #(
    .MAX_LEDS (MAX_LEDS),
    .AW       (AW)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .led_cnt        (led_cnt),
    .head_op        (head_op),
    .empty          (q_empty),
    .pop            (pop),
    .clearing       (clearing),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .out_valid      (out_valid),
    .out_line_level (out_line_level),
    .out_busy_res   (out_busy_res),
    .out_frame_done (out_frame_done),
    .out_accepted   (out_accepted)
  );

  wsft_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_LEDS),
    .AW    (AW)
  ) u_color_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

/* test/tb_ws2812_frame_transmitter_top.sv */
// self-checking testbench for ws2812_frame_transmitter_top: a directed table, then random
// command beats under three sender idle profiles, checked against a strip predictor
// depends on wsft_pkg and the ws2812_frame_transmitter_top rtl
module tb_ws2812_frame_transmitter_top;
  timeunit 1ns;
  timeprecision 1ps;
  import wsft_pkg::*;

  localparam int          STRIP_LEDS     = MAX_LEDS_DEF;
  localparam int unsigned ITEMS_PER_MODE = 410;
  localparam int unsigned CYCLE_LIMIT    = 400000;

  typedef struct packed {
    func_t             func;
    logic [BYTE_W-1:0] led_index;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
  } led_cmd_t;

  typedef struct packed {
    logic level;
    logic busy;
    logic done;
    logic acc;
  } line_resp_t;

  typedef struct packed {
    logic             is_reg;
    cfg_idx_t         reg_idx;
    logic [CFG_W-1:0] reg_val;
    led_cmd_t         cmd;
    logic             typed;
    line_resp_t       want;
  } dir_step_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [FUNC_W-1:0]    in_func = '0;
  logic [BYTE_W-1:0]    in_led_index = '0;
  logic [BYTE_W-1:0]    in_red = '0;
  logic [BYTE_W-1:0]    in_green = '0;
  logic [BYTE_W-1:0]    in_blue = '0;
  logic                 out_valid;
  logic                 out_line_level;
  logic                 out_busy_res;
  logic                 out_frame_done;
  logic                 out_accepted;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  ws2812_frame_transmitter_top dut (.*);

  always #6 clk = ~clk;

  // strip predictor state
  logic [WORD_W-1:0]    strip_colors [STRIP_LEDS];
  logic                 frame_on;
  logic                 in_latch;
  logic [CFG_W-1:0]     slot_tick;
  logic [BIT_W-1:0]     bit_pos;
  logic [5:0]           led_pos;
  logic [CFG_W-1:0]     latch_slot;
  logic [CFG_W-1:0]     period_r;
  logic [CFG_W-1:0]     one_high_r;
  logic [CFG_W-1:0]     zero_high_r;
  logic [CFG_W-1:0]     latch_slots_r;
  logic [LED_CNT_W-1:0] led_count_r;

  line_resp_t  pending_responses [$];
  int unsigned idle_pct = 17;
  int unsigned beats_sent = 0;
  int unsigned useful_cnt = 0;
  int unsigned refused_cnt = 0;
  int unsigned reg_writes = 0;
  int unsigned frames_done = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;

  function automatic int unsigned leds_in_use();
    return (32'(led_count_r) > STRIP_LEDS) ? STRIP_LEDS : 32'(led_count_r);
  endfunction

  function automatic void stop_frame();
    frame_on   = 1'b0;
    in_latch   = 1'b0;
    slot_tick  = '0;
    bit_pos    = '0;
    led_pos    = '0;
    latch_slot = '0;
  endfunction

  function automatic void reset_strip_model();
    period_r      = PERIOD_RST;
    one_high_r    = ONE_HIGH_RST;
    zero_high_r   = ZERO_HIGH_RST;
    latch_slots_r = RST_SLOTS_RST;
    led_count_r   = LED_CNT_RST;
    foreach (strip_colors[i]) strip_colors[i] = '0;
    stop_frame();
  endfunction

  // called after the last tick of a slot, returns 1 when the frame ends
  function automatic logic advance_slot();
    slot_tick = '0;
    if (in_latch) begin
      if (32'(latch_slot) + 32'd1 >= 32'(latch_slots_r)) begin
        stop_frame();
        return 1'b1;
      end
      latch_slot = latch_slot + 16'd1;
      return 1'b0;
    end
    if (bit_pos < LAST_BIT) begin
      bit_pos = bit_pos + 5'd1;
      return 1'b0;
    end
    bit_pos = '0;
    if (32'(led_pos) + 32'd1 < leds_in_use()) begin
      led_pos = led_pos + 6'd1;
      return 1'b0;
    end
    if (latch_slots_r == '0) begin
      stop_frame();
      return 1'b1;
    end
    in_latch   = 1'b1;
    latch_slot = '0;
    return 1'b0;
  endfunction

  function automatic line_resp_t predict_strip_response(led_cmd_t c);
    line_resp_t        r;
    int unsigned       n;
    logic [WORD_W-1:0] grb;
    logic [CFG_W-1:0]  high;
    r   = '0;
    n   = leds_in_use();
    grb = {c.green, c.red, c.blue};
    if (c.func == FUNC_TICK) begin
      r.acc = 1'b1;
      if (frame_on) begin
        high = '0;
        if (!in_latch)
          high = strip_colors[led_pos][LAST_BIT - bit_pos] ? one_high_r : zero_high_r;
        r.level = (slot_tick < high);
        if (32'(slot_tick) + 32'd1 >= 32'(period_r))
          r.done = advance_slot();
        else
          slot_tick = slot_tick + 16'd1;
      end
    end else if (!frame_on) begin
      case (c.func)
        FUNC_SET_ONE: begin
          if (32'(c.led_index) < n) begin
            strip_colors[c.led_index[5:0]] = grb;
            r.acc = 1'b1;
          end
        end
        FUNC_SET_ALL: begin
          for (int i = 0; i < int'(n); i++) strip_colors[i] = grb;
          r.acc = 1'b1;
        end
        default: begin
          r.acc = 1'b1;
          stop_frame();
          if (!(n == 0 && latch_slots_r == '0)) begin
            frame_on = 1'b1;
            in_latch = (n == 0);
          end
        end
      endcase
    end
    r.busy = frame_on;
    return r;
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_PERIOD:    period_r = val;
      CFG_ONE_HIGH:  one_high_r = val;
      CFG_ZERO_HIGH: zero_high_r = val;
      CFG_RST_SLOTS: latch_slots_r = val;
      CFG_LED_COUNT: led_count_r = val[LED_CNT_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic send_beat(led_cmd_t c, logic typed, line_resp_t want);
    line_resp_t model;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    in_func      <= c.func;
    in_led_index <= c.led_index;
    in_red       <= c.red;
    in_green     <= c.green;
    in_blue      <= c.blue;
    do @(posedge clk); while (busy);
    model = predict_strip_response(c);
    pending_responses.push_back(typed ? want : model);
    beats_sent++;
    if (model.acc) useful_cnt++;
    else refused_cnt++;
  endtask

  // hold the sender off until every pending beat has come back
  task automatic settle();
    start <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] pick_timing(int unsigned common_max);
    if ($urandom_range(0, 15) == 0) return CFG_W'($urandom);
    return CFG_W'($urandom_range(0, common_max));
  endfunction

  task automatic program_random_timing();
    logic [LED_CNT_W-1:0] cnt;
    cnt = ($urandom_range(0, 15) == 0) ? LED_CNT_W'($urandom)
                                       : LED_CNT_W'($urandom_range(0, 3));
    write_reg(CFG_PERIOD, pick_timing(5));
    write_reg(CFG_ONE_HIGH, pick_timing(7));
    write_reg(CFG_ZERO_HIGH, pick_timing(7));
    write_reg(CFG_RST_SLOTS, pick_timing(4));
    write_reg(CFG_LED_COUNT, {9'($urandom), cnt});
  endtask

  function automatic led_cmd_t random_beat();
    led_cmd_t    c;
    int unsigned roll;
    roll        = $urandom_range(0, 99);
    c.led_index = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                              : 8'($urandom_range(0, leds_in_use()));
    c.red       = 8'($urandom);
    c.green     = 8'($urandom);
    c.blue      = 8'($urandom);
    if (frame_on)
      c.func = (roll < 85) ? FUNC_TICK : func_t'($urandom_range(0, 2));
    else if (roll < 35)
      c.func = FUNC_SET_ONE;
    else if (roll < 40)
      c.func = FUNC_SET_ALL;
    else if (roll < 65)
      c.func = FUNC_START;
    else
      c.func = FUNC_TICK;
    return c;
  endfunction

  function automatic dir_step_t cmd_row(func_t f, logic [7:0] idx, logic [7:0] g,
                                        logic [7:0] r, logic [7:0] b, logic typed,
                                        line_resp_t want);
    dir_step_t s;
    s       = '0;
    s.cmd   = '{func: f, led_index: idx, red: r, green: g, blue: b};
    s.typed = typed;
    s.want  = want;
    return s;
  endfunction

  function automatic dir_step_t reg_row(cfg_idx_t idx, logic [CFG_W-1:0] val);
    dir_step_t s;
    s         = '0;
    s.is_reg  = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  task automatic report_mismatch(string what, line_resp_t e, line_resp_t g);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("%s: exp level %0b busy %0b done %0b acc %0b, %s%0b busy %0b done %0b acc %0b",
               what, e.level, e.busy, e.done, e.acc, "got level ",
               g.level, g.busy, g.done, g.acc);
  endtask

  always @(posedge clk) begin
    line_resp_t seen;
    line_resp_t exp_r;
    if (rst_n && out_valid) begin
      seen = {out_line_level, out_busy_res, out_frame_done, out_accepted};
      if (seen.done) frames_done++;
      if (pending_responses.size() == 0) begin
        report_mismatch("unexpected result", 'x, seen);
      end else begin
        exp_r = pending_responses.pop_front();
        if (seen !== exp_r) report_mismatch("result mismatch", exp_r, seen);
      end
    end
  end

  initial begin
    for (cycle_cnt = 0; cycle_cnt < CYCLE_LIMIT; cycle_cnt++) @(posedge clk);
    $display("ws2812_frame_transmitter_top verification failed");
    $finish;
  end

  initial begin
    dir_step_t   dir_steps [$];
    int unsigned goal;
    reset_strip_model();
    // want bits: level, busy, done, accepted
    dir_steps = {
      cmd_row(FUNC_TICK,    8'd0,   8'h00, 8'h00, 8'h00, 1'b1, 4'b0001),
      cmd_row(FUNC_SET_ONE, 8'd0,   8'h00, 8'hff, 8'h55, 1'b1, 4'b0001),
      cmd_row(FUNC_SET_ONE, 8'd1,   8'hff, 8'hff, 8'hff, 1'b1, 4'b0000),
      cmd_row(FUNC_SET_ONE, 8'd255, 8'hff, 8'hff, 8'hff, 1'b1, 4'b0000),
      reg_row(CFG_LED_COUNT, 16'd127),
      cmd_row(FUNC_SET_ALL, 8'd0,   8'ha5, 8'h5a, 8'hff, 1'b1, 4'b0001),
      cmd_row(FUNC_SET_ONE, 8'd63,  8'hff, 8'h00, 8'h00, 1'b1, 4'b0001),
      cmd_row(FUNC_SET_ONE, 8'd64,  8'h00, 8'h00, 8'h00, 1'b1, 4'b0000),
      reg_row(CFG_LED_COUNT, 16'd0),
      reg_row(CFG_RST_SLOTS, 16'd0),
      cmd_row(FUNC_START,   8'd0,   8'h00, 8'h00, 8'h00, 1'b1, 4'b0001),
      cmd_row(FUNC_TICK,    8'd0,   8'h00, 8'h00, 8'h00, 1'b1, 4'b0001),
      reg_row(CFG_RST_SLOTS, 16'd1),
      reg_row(CFG_PERIOD, 16'd1),
      cmd_row(FUNC_START,   8'd0,   8'h00, 8'h00, 8'h00, 1'b1, 4'b0101),
      cmd_row(FUNC_SET_ALL, 8'd0,   8'hff, 8'hff, 8'hff, 1'b1, 4'b0100),
      cmd_row(FUNC_TICK,    8'd0,   8'h00, 8'h00, 8'h00, 1'b1, 4'b0011),
      reg_row(CFG_PERIOD, 16'hffff),
      reg_row(CFG_ONE_HIGH, 16'hffff),
      reg_row(CFG_ZERO_HIGH, 16'd0),
      reg_row(CFG_RST_SLOTS, 16'hffff),
      reg_row(CFG_LED_COUNT, 16'd1),
      cmd_row(FUNC_SET_ONE, 8'd0,   8'h80, 8'h00, 8'h01, 1'b1, 4'b0001),
      cmd_row(FUNC_START,   8'd0,   8'h00, 8'h00, 8'h00, 1'b1, 4'b0101),
      cmd_row(FUNC_TICK,    8'd0,   8'h00, 8'h00, 8'h00, 1'b1, 4'b1101),
      cmd_row(FUNC_SET_ONE, 8'd0,   8'h12, 8'h34, 8'h56, 1'b1, 4'b0100),
      cmd_row(FUNC_START,   8'd0,   8'h00, 8'h00, 8'h00, 1'b1, 4'b0100),
      reg_row(CFG_PERIOD, 16'd0),
      cmd_row(FUNC_TICK,    8'd0,   8'h00, 8'h00, 8'h00, 1'b0, 4'b0000),
      cmd_row(FUNC_TICK,    8'd0,   8'h00, 8'h00, 8'h00, 1'b0, 4'b0000),
      reg_row(CFG_LED_COUNT, 16'd0),
      reg_row(CFG_ZERO_HIGH, 16'hffff),
      cmd_row(FUNC_TICK,    8'd0,   8'h00, 8'h00, 8'h00, 1'b0, 4'b0000),
      cmd_row(FUNC_TICK,    8'd0,   8'h00, 8'h00, 8'h00, 1'b0, 4'b0000)
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_steps[k]) begin
      if (dir_steps[k].is_reg) begin
        settle();
        write_reg(dir_steps[k].reg_idx, dir_steps[k].reg_val);
      end else begin
        send_beat(dir_steps[k].cmd, dir_steps[k].typed, dir_steps[k].want);
      end
    end

    for (int mode = 0; mode < 3; mode++) begin
      idle_pct = (mode == 0) ? 17 : (mode == 1) ? 63 : 0;
      goal = beats_sent + ITEMS_PER_MODE;
      while (beats_sent < goal) begin
        settle();
        program_random_timing();
        repeat ($urandom_range(40, 150)) begin
          if (beats_sent < goal) send_beat(random_beat(), 1'b0, '0);
        end
      end
    end

    settle();
    repeat (16) @(posedge clk);
    if (pending_responses.size() != 0) begin
      mismatch_cnt += pending_responses.size();
      $display("%0d results never arrived", pending_responses.size());
    end

    $display("sent %0d command beats (%0d carried out, %0d refused), %0d register writes",
             beats_sent, useful_cnt, refused_cnt, reg_writes);
    $display("saw %0d completed frames over %0d cycles, %0d mismatches",
             frames_done, cycle_cnt, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("ws2812_frame_transmitter_top verification clean");
    end else begin
      $display("ws2812_frame_transmitter_top verification failed");
    end
    $finish;
  end

endmodule
